// ===== rtl/ils_pkg.sv =====
// ils_pkg: shared constants, request/status codes and cell control types
// for the indexed list store. No dependencies.
package ils_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;

   // word field widths
   localparam int TYPE_W   = 3;
   localparam int POS_W    = 7;
   localparam int ELEM_W   = 32;
   localparam int READ_W   = 32;
   localparam int STATUS_W = 2;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   // readout tree
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_APPEND    = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_INSERT    = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_READ      = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_REMOVE    = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_OVERWRITE = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_CLEAR     = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // cell operations
   localparam logic [1:0] CELL_HOLD       = 2'd0;
   localparam logic [1:0] CELL_WRITE      = 2'd1;
   localparam logic [1:0] CELL_SHIFT_UP   = 2'd2;
   localparam logic [1:0] CELL_SHIFT_DOWN = 2'd3;

   typedef struct packed {
      logic [1:0]             op;
      logic                   rd_en;
      logic [IDX_W-1:0]       pos;
      logic [VALUE_WIDTH-1:0] value;
   } cell_ctl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    count;
      logic                empty;
      logic                full;
   } req_result_type;

endpackage

// ===== rtl/ils_channels.sv =====
// ils_req_if / ils_rsp_if: valid/ready channels for request and result words.
// Depends on ils_pkg.
interface ils_req_if;
   import ils_pkg::*;
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [POS_W-1:0]  position;
   logic [ELEM_W-1:0] elem_value;
   modport source (output valid, req_type, position, elem_value, input ready);
   modport sink   (input valid, req_type, position, elem_value, output ready);
endinterface

interface ils_rsp_if;
   import ils_pkg::*;
   logic                valid;
   logic                ready;
   logic [READ_W-1:0]   read_value;
   logic [STATUS_W-1:0] status;
   logic [CNT_W-1:0]    entry_count;
   logic                is_empty;
   logic                is_full;
   modport source (output valid, read_value, status, entry_count, is_empty, is_full,
                   input ready);
   modport sink   (input valid, read_value, status, entry_count, is_empty, is_full,
                   output ready);
endinterface

// ===== rtl/ils_cell.sv =====
// ils_cell: one list entry; loads, or takes a neighbor's entry on a shift.
// Depends on ils_pkg.
module ils_cell (
   input  logic                                clock,
   input  ils_pkg::cell_ctl_type               cell_ctl,
   input  logic [ils_pkg::IDX_W-1:0]           cell_index,
   input  logic [ils_pkg::VALUE_WIDTH-1:0]     left_value,
   input  logic [ils_pkg::VALUE_WIDTH-1:0]     right_value,
   output logic [ils_pkg::VALUE_WIDTH-1:0]     entry_value,
   output logic [ils_pkg::VALUE_WIDTH-1:0]     hit_value
);
   import ils_pkg::*;

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;
   logic                   at_pos;
   logic                   above_pos;

   assign at_pos    = (cell_index == cell_ctl.pos);
   assign above_pos = (cell_index > cell_ctl.pos);

   always_comb begin
      entry_in = entry_ff;
      unique case (cell_ctl.op)
         CELL_WRITE: begin
            if (at_pos) entry_in = cell_ctl.value;
         end
         CELL_SHIFT_UP: begin
            if (above_pos) entry_in = left_value;
            else if (at_pos) entry_in = cell_ctl.value;
         end
         CELL_SHIFT_DOWN: begin
            if (at_pos || above_pos) entry_in = right_value;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   assign hit_value   = (cell_ctl.rd_en && at_pos) ? entry_ff : '0;

endmodule

// ===== rtl/ils_readout.sv =====
// ils_readout: two-level registered OR tree that collects the read hit.
// Depends on ils_pkg.
module ils_readout (
   input  logic                            clock,
   input  logic                            capture,
   input  logic [ils_pkg::VALUE_WIDTH-1:0] hit_values [ils_pkg::CAPACITY],
   output logic [ils_pkg::READ_W-1:0]      read_value
);
   import ils_pkg::*;

   logic [VALUE_WIDTH-1:0] group_ff [NUM_GROUPS];
   logic [VALUE_WIDTH-1:0] group_in [NUM_GROUPS];
   logic [VALUE_WIDTH-1:0] merged;

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY)
               group_in[g] = group_in[g] | hit_values[g * GROUP_SIZE + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         for (int g = 0; g < NUM_GROUPS; g++) group_ff[g] <= group_in[g];
      end
   end

   always_comb begin
      merged = '0;
      for (int g = 0; g < NUM_GROUPS; g++) merged = merged | group_ff[g];
   end

   assign read_value = READ_W'(merged);

endmodule

// ===== rtl/ils_ctrl.sv =====
// ils_ctrl: entry count, request decode and range/full checks; drives the cell row.
// Depends on ils_pkg.
module ils_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [ils_pkg::TYPE_W-1:0]   req_type,
   input  logic [ils_pkg::POS_W-1:0]    position,
   input  logic [ils_pkg::ELEM_W-1:0]   elem_value,
   output ils_pkg::cell_ctl_type        cell_ctl,
   output ils_pkg::req_result_type      result
);
   import ils_pkg::*;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W-1:0]    count_next;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    cnt_ext;
   logic                list_full;
   logic [1:0]          op_sel;
   logic                rd_sel;
   logic [IDX_W-1:0]    pos_sel;
   logic [STATUS_W-1:0] status;

   assign pos_ext   = CMP_W'(position);
   assign cnt_ext   = CMP_W'(count_ff);
   assign list_full = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      op_sel     = CELL_HOLD;
      rd_sel     = 1'b0;
      pos_sel    = position[IDX_W-1:0];
      status     = ST_OK;
      count_next = count_ff;
      unique case (req_type)
         REQ_APPEND: begin
            if (list_full) status = ST_FULL;
            else begin
               op_sel     = CELL_WRITE;
               pos_sel    = count_ff[IDX_W-1:0];
               count_next = count_ff + 1'b1;
            end
         end
         REQ_INSERT: begin
            if (pos_ext > cnt_ext) status = ST_RANGE;
            else if (list_full) status = ST_FULL;
            else begin
               op_sel     = CELL_SHIFT_UP;
               count_next = count_ff + 1'b1;
            end
         end
         REQ_READ: begin
            if (pos_ext >= cnt_ext) status = ST_RANGE;
            else rd_sel = 1'b1;
         end
         REQ_REMOVE: begin
            if (pos_ext >= cnt_ext) status = ST_RANGE;
            else begin
               op_sel     = CELL_SHIFT_DOWN;
               count_next = count_ff - 1'b1;
            end
         end
         REQ_OVERWRITE: begin
            if (pos_ext >= cnt_ext) status = ST_RANGE;
            else op_sel = CELL_WRITE;
         end
         REQ_CLEAR: count_next = '0;
         default: status = ST_OK;  // unknown kinds are ignored
      endcase
   end

   assign count_in = take ? count_next : count_ff;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   assign cell_ctl.op    = take ? op_sel : CELL_HOLD;
   assign cell_ctl.rd_en = take && rd_sel;
   assign cell_ctl.pos   = pos_sel;
   assign cell_ctl.value = VALUE_WIDTH'(elem_value);

   assign result.status = status;
   assign result.count  = count_next;
   assign result.empty  = (count_next == '0);
   assign result.full   = (count_next == CNT_W'(CAPACITY));

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_grow: assert property (@(posedge clock) disable iff (reset)
      take && (req_type == REQ_APPEND || req_type == REQ_INSERT) && status == ST_OK
      |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("accepted add did not grow the list by one");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      take && req_type == REQ_CLEAR |=> count_ff == '0)
      else $error("clear left entries counted");
`endif

endmodule

// ===== rtl/indexed_list_store.sv =====
// indexed_list_store: ordered list with positional insert/remove in a row of cells.
// Throughput: one request per cycle unless the result side stalls; every cell
//   shifts in the accept cycle, the request then waits in the pending stage for
//   the result register; the read value goes via a two-level registered OR tree.
// Reset: clears the entry count and handshake state; entry cells are not
//   cleared (nothing beyond the count is reachable).
module indexed_list_store (
   input  logic       clock,
   input  logic       reset,
   ils_req_if.sink    req_chan,
   ils_rsp_if.source  rsp_chan
);
   import ils_pkg::*;

   // handshake
   logic take;
   logic pend_move;

   // pending stage: state already updated, read value in the tree
   logic           pend_ff;
   logic           pend_in;
   req_result_type pend_result_ff;

   // result register, parts the two sides
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [READ_W-1:0]   read_value_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                empty_ff;
   logic                full_ff;

   cell_ctl_type           cell_ctl;
   req_result_type         result;
   logic [VALUE_WIDTH-1:0] entry_values [CAPACITY];
   logic [VALUE_WIDTH-1:0] hit_values   [CAPACITY];
   logic [READ_W-1:0]      tree_value;

   // pending word moves out when the result register is free or drained
   assign pend_move      = pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !pend_ff || pend_move;
   assign take           = req_chan.valid && req_chan.ready;

   ils_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .req_type   (req_chan.req_type),
      .position   (req_chan.position),
      .elem_value (req_chan.elem_value),
      .cell_ctl   (cell_ctl),
      .result     (result)
   );

   // row of cells: each sees its left and right neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_value;
      logic [VALUE_WIDTH-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = entry_values[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = entry_values[i];
      end else begin : g_right
         assign right_value = entry_values[i+1];
      end
      ils_cell u_cell (
         .clock       (clock),
         .cell_ctl    (cell_ctl),
         .cell_index  (IDX_W'(i)),
         .left_value  (left_value),
         .right_value (right_value),
         .entry_value (entry_values[i]),
         .hit_value   (hit_values[i])
      );
   end

   // tree captures the hit at accept; holds until the next accept
   ils_readout u_readout (
      .clock      (clock),
      .capture    (take),
      .hit_values (hit_values),
      .read_value (tree_value)
   );

   always_comb begin
      pend_in = pend_ff;
      if (take) pend_in = 1'b1;
      else if (pend_move) pend_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (pend_move) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take) pend_result_ff <= result;
      if (pend_move) begin
         read_value_ff <= tree_value;
         status_ff     <= pend_result_ff.status;
         count_ff      <= pend_result_ff.count;
         empty_ff      <= pend_result_ff.empty;
         full_ff       <= pend_result_ff.full;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = read_value_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.entry_count = count_ff;
   assign rsp_chan.is_empty    = empty_ff;
   assign rsp_chan.is_full     = full_ff;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for indexed_list_store; random list traffic with
// a built-in list predictor. Depends on ils_pkg, ils_channels and the block RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ils_pkg::*;

   // request kinds the block must ignore (still one result word, status ok)
   localparam logic [TYPE_W-1:0] REQ_RSVD_LO = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_RSVD_HI = 3'd7;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES      = 8;    // margin after the last result

   typedef struct {
      logic [TYPE_W-1:0] kind;
      logic [POS_W-1:0]  pos;
      logic [ELEM_W-1:0] value;
   } list_req_type;

   typedef struct {
      logic [READ_W-1:0]   read_value;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    entry_count;
      logic                is_empty;
      logic                is_full;
   } list_result_type;

   logic clock;
   logic reset = 1'b1;

   ils_req_if req_if ();
   ils_rsp_if rsp_if ();

   indexed_list_store dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Shared bench state
   // ---------------------------------------------------------------------
   list_req_type    pending_requests[$];   // words still to be offered
   list_result_type awaited_results[$];    // predicted words, oldest first
   list_req_type    on_wire;               // word currently offered

   logic [VALUE_WIDTH-1:0] list_cells[CAPACITY];  // predicted list contents
   int  list_len = 0;                              // predicted entry count
   int  plan_len = 0;                              // count as seen by the generator

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  hold_armed     = 1'b0;
   logic rsp_hold      = 1'b0;

   int  cycle_count    = 0;
   int  results_seen   = 0;
   int  mismatch_count = 0;

   // ---------------------------------------------------------------------
   // Clock, and every block input known from time zero
   // ---------------------------------------------------------------------
   initial begin
      clock             = 1'b0;
      req_if.valid      = 1'b0;
      req_if.req_type   = REQ_APPEND;
      req_if.position   = '0;
      req_if.elem_value = '0;
      rsp_if.ready      = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // List predictor: applies one request to the predicted list, returns the
   // result word the block should give for it.
   // ---------------------------------------------------------------------
   function automatic list_result_type step_list(list_req_type r);
      list_result_type res;
      int i;
      res.read_value = '0;
      res.status     = ST_OK;
      case (r.kind)
         REQ_APPEND: begin
            if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               list_cells[list_len] = r.value[VALUE_WIDTH-1:0];
               list_len++;
            end
         end
         REQ_INSERT: begin
            // range test wins over the full test
            if (r.pos > list_len) begin
               res.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (i = list_len; i > r.pos; i--)
                  list_cells[i] = list_cells[i-1];
               list_cells[r.pos] = r.value[VALUE_WIDTH-1:0];
               list_len++;
            end
         end
         REQ_READ: begin
            if (r.pos >= list_len)
               res.status = ST_RANGE;
            else
               res.read_value = READ_W'(list_cells[r.pos]);
         end
         REQ_REMOVE: begin
            if (r.pos >= list_len) begin
               res.status = ST_RANGE;
            end else begin
               for (i = r.pos; i + 1 < list_len; i++)
                  list_cells[i] = list_cells[i+1];
               list_len--;
            end
         end
         REQ_OVERWRITE: begin
            if (r.pos >= list_len)
               res.status = ST_RANGE;
            else
               list_cells[r.pos] = r.value[VALUE_WIDTH-1:0];
         end
         REQ_CLEAR: list_len = 0;   // cells keep their contents, unreachable
         default: ;                 // reserved kinds change nothing
      endcase
      res.entry_count = CNT_W'(list_len);
      res.is_empty    = (list_len == 0);
      res.is_full     = (list_len == CAPACITY);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one word in flight on req; prediction happens at acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            awaited_results.push_back(step_list(on_wire));
         // slot is free when nothing is offered or the offer just went in
         if (!req_if.valid || req_if.ready) begin
            offer = (pending_requests.size() != 0) &&
                    ($urandom_range(99) >= send_idle_pct);
            if (offer) begin
               on_wire           = pending_requests.pop_front();
               req_if.valid      <= 1'b1;
               req_if.req_type   <= on_wire.kind;
               req_if.position   <= on_wire.pos;
               req_if.elem_value <= on_wire.value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each accepted result word with the oldest prediction
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               report_mismatch("word arrived with nothing outstanding");
            end else begin
               want = awaited_results.pop_front();
               if (rsp_if.read_value !== want.read_value)
                  report_mismatch($sformatf("read_value %h, want %h",
                                            rsp_if.read_value, want.read_value));
               if (rsp_if.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_if.status, want.status));
               if (rsp_if.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count %0d, want %0d",
                                            rsp_if.entry_count, want.entry_count));
               if (rsp_if.is_empty !== want.is_empty)
                  report_mismatch($sformatf("is_empty %b, want %b",
                                            rsp_if.is_empty, want.is_empty));
               if (rsp_if.is_full !== want.is_full)
                  report_mismatch($sformatf("is_full %b, want %b",
                                            rsp_if.is_full, want.is_full));
            end
         end
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off, counted here so the sender keeps pushing and
   // the block backs up into its input
   initial begin
      int held;
      wait (hold_armed);
      rsp_hold <= 1'b1;
      for (held = 0; held < LONG_HOLD_CYCLES; held++)
         @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------
   // queue one word; plan_len tracks the count so positions stay mostly legal
   task automatic queue_req(logic [TYPE_W-1:0] kind, logic [POS_W-1:0] pos,
                            logic [ELEM_W-1:0] value);
      list_req_type r;
      r.kind  = kind;
      r.pos   = pos;
      r.value = value;
      pending_requests.push_back(r);
      case (kind)
         REQ_APPEND:  if (plan_len < CAPACITY) plan_len++;
         REQ_INSERT:  if (pos <= plan_len && plan_len < CAPACITY) plan_len++;
         REQ_REMOVE:  if (pos < plan_len) plan_len--;
         REQ_CLEAR:   plan_len = 0;
         default: ;
      endcase
   endtask

   task automatic queue_random(int grow_pct, int clear_pct);
      int roll;
      logic [TYPE_W-1:0] kind;
      logic [POS_W-1:0]  pos;
      logic [ELEM_W-1:0] value;
      roll = $urandom_range(99);
      if (roll < clear_pct) begin
         kind = REQ_CLEAR;
      end else if (roll < clear_pct + 2) begin
         kind = ($urandom_range(1) == 1) ? REQ_RSVD_HI : REQ_RSVD_LO;
      end else begin
         roll = $urandom_range(99);
         if (roll < grow_pct)
            kind = ($urandom_range(1) == 1) ? REQ_APPEND : REQ_INSERT;
         else if (roll < grow_pct + (100 - grow_pct) / 2)
            kind = REQ_REMOVE;
         else
            kind = ($urandom_range(1) == 1) ? REQ_READ : REQ_OVERWRITE;
      end
      // mostly in or at the edge of the list, some past it, a few anywhere
      roll = $urandom_range(99);
      if (roll < 85)
         pos = POS_W'($urandom_range(plan_len));
      else if (roll < 95)
         pos = POS_W'($urandom_range(CAPACITY));
      else
         pos = POS_W'($urandom_range((1 << POS_W) - 1));
      roll = $urandom_range(99);
      if (roll < 8)
         value = '0;
      else if (roll < 16)
         value = '1;
      else
         value = ELEM_W'($urandom);
      queue_req(kind, pos, value);
   endtask

   // sender pause: nothing pending, nothing offered, every result back
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_if.valid ||
             awaited_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int grow_pct,
                            int clear_pct, int items);
      int n;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < items; n++)
         queue_random(grow_pct, clear_pct);
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty-list errors, edge values, insert at head and at
      // the count, out-of-range insert, far positions, reserved kinds, clear
      queue_req(REQ_READ,      7'd0,  32'h0);
      queue_req(REQ_REMOVE,    7'd0,  32'h0);
      queue_req(REQ_OVERWRITE, 7'd0,  32'h1);
      queue_req(REQ_APPEND,    7'd0,  32'h0000_0000);
      queue_req(REQ_APPEND,    7'd0,  32'hFFFF_FFFF);
      queue_req(REQ_INSERT,    7'd0,  32'h1234_5678);
      queue_req(REQ_INSERT,    7'd3,  32'hA5A5_A5A5);   // at count: acts as append
      queue_req(REQ_INSERT,    7'd5,  32'hDEAD_BEEF);   // past count: range error
      queue_req(REQ_READ,      7'd0,  32'h0);
      queue_req(REQ_READ,      7'd1,  32'h0);
      queue_req(REQ_READ,      7'd2,  32'h0);
      queue_req(REQ_READ,      7'd3,  32'h0);
      queue_req(REQ_READ,      7'd4,  32'h0);
      queue_req(REQ_READ,      7'd127, 32'h0);
      queue_req(REQ_OVERWRITE, 7'd1,  32'h5A5A_5A5A);
      queue_req(REQ_READ,      7'd1,  32'h0);
      queue_req(REQ_REMOVE,    7'd0,  32'h0);
      queue_req(REQ_REMOVE,    7'd3,  32'h0);           // at count: range error
      queue_req(REQ_READ,      7'd0,  32'h0);
      queue_req(REQ_RSVD_LO,   7'd0,  32'hFFFF_FFFF);
      queue_req(REQ_RSVD_HI,   7'd127, 32'h0);
      queue_req(REQ_CLEAR,     7'd0,  32'h0);
      queue_req(REQ_READ,      7'd0,  32'h0);
      queue_req(REQ_APPEND,    7'd0,  32'h8000_0000);
      queue_req(REQ_READ,      7'd0,  32'h0);
      wait_drained();

      // random phases; the first fills the list to hit the full status
      run_phase( 0,  0, 80, 0, 350);
      run_phase(67,  0, 25, 1, 350);
      run_phase( 0, 67, 60, 1, 350);
      run_phase(19, 19, 35, 1, 350);

      // receiver holds off while the sender streams with no gaps
      hold_armed = 1'b1;
      run_phase( 0,  0, 50, 1, 300);

      run_phase( 0,  0, 40, 2, 200);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
